// ===== hw/rtl/c2dvw_pkg.sv =====
// ----------------------------------------------------------------------------
// c2dvw_pkg: shared types and constants for the 3x3 valid-window correlator
// Register indexes, size limits, coefficient format and pipeline controls.
// ----------------------------------------------------------------------------
package c2dvw_pkg;

    localparam int KERNEL_SIZE   = 3;
    localparam int MAX_WIDTH     = 1024;
    localparam int SAMPLE_BITS   = 16;

    localparam int COEF_BITS     = 16;
    localparam int KROW_BITS     = KERNEL_SIZE * COEF_BITS;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 48;

    localparam int IMG_W_BITS    = 11;
    localparam int IMG_H_BITS    = 13;
    localparam int ROW_BITS      = 12;
    // wide enough for any clamped size and counter + 1
    localparam int CMP_BITS      = 14;

    localparam int MIN_SIZE      = 3;
    localparam int MAX_HEIGHT    = 4096;
    localparam int IMG_W_RESET   = 1024;
    localparam int IMG_H_RESET   = 4096;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_IMAGE_WIDTH   = 3'd0,
        CFG_IMAGE_HEIGHT  = 3'd1,
        CFG_KERNEL_TOP    = 3'd2,
        CFG_KERNEL_MIDDLE = 3'd3,
        CFG_KERNEL_BOTTOM = 3'd4
    } t_cfg_idx;

    // stage advance strobes for the datapath
    typedef struct packed {
        logic move1;     // stage 1 -> products
        logic move2;     // products -> row sums
        logic load_out;  // row sums -> output register
    } t_pipe_ctl;

endpackage

// ===== hw/rtl/c2dvw_linebuf.sv =====
// ----------------------------------------------------------------------------
// c2dvw_linebuf: two line stores for the rows above the current one
// Registered read of both stores, write-back of sample and row above.
// ----------------------------------------------------------------------------
module c2dvw_linebuf #(
    parameter int SAMPLE_BITS = c2dvw_pkg::SAMPLE_BITS,
    parameter int MAX_WIDTH   = c2dvw_pkg::MAX_WIDTH,
    parameter int ADDR_BITS   = $clog2(MAX_WIDTH)
) (
    input  logic                          i_clk,
    input  logic                          i_rd_en,
    input  logic [ADDR_BITS-1:0]          i_rd_addr,
    input  logic                          i_wr_en,
    input  logic [ADDR_BITS-1:0]          i_wr_addr,
    input  logic signed [SAMPLE_BITS-1:0] i_wr_sample,
    output logic signed [SAMPLE_BITS-1:0] o_top,
    output logic signed [SAMPLE_BITS-1:0] o_mid
);

    logic signed [SAMPLE_BITS-1:0] r_store_a [MAX_WIDTH];  // row above
    logic signed [SAMPLE_BITS-1:0] r_store_b [MAX_WIDTH];  // two rows above
    logic signed [SAMPLE_BITS-1:0] r_rd_a;
    logic signed [SAMPLE_BITS-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_a <= r_store_a[i_rd_addr];
            r_rd_b <= r_store_b[i_rd_addr];
        end
        // row above moves down one store, new sample enters the first
        if (i_wr_en) begin
            r_store_a[i_wr_addr] <= i_wr_sample;
            r_store_b[i_wr_addr] <= r_rd_a;
        end
    end

    assign o_top = r_rd_b;
    assign o_mid = r_rd_a;

endmodule

// ===== hw/rtl/c2dvw_mac.sv =====
// ----------------------------------------------------------------------------
// c2dvw_mac: 3x3 window, nine products, row sums and output register
// Window shifts once per item; products and sums are each registered.
// ----------------------------------------------------------------------------
module c2dvw_mac #(
    parameter int SAMPLE_BITS = c2dvw_pkg::SAMPLE_BITS,
    parameter int SUM_BITS    = SAMPLE_BITS + c2dvw_pkg::COEF_BITS + 3
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  c2dvw_pkg::t_pipe_ctl               i_ctl,
    input  logic signed [SAMPLE_BITS-1:0]      i_top,
    input  logic signed [SAMPLE_BITS-1:0]      i_mid,
    input  logic signed [SAMPLE_BITS-1:0]      i_sample,
    input  logic [c2dvw_pkg::KERNEL_SIZE-1:0][c2dvw_pkg::KROW_BITS-1:0] i_kernel,
    output logic signed [SUM_BITS-1:0]         o_filtered
);

    localparam int KS        = c2dvw_pkg::KERNEL_SIZE;
    localparam int CB        = c2dvw_pkg::COEF_BITS;
    localparam int PROD_BITS = SUM_BITS - 3;
    localparam int RSUM_BITS = PROD_BITS + 1;

    logic signed [SAMPLE_BITS-1:0] r_win [KS][KS];
    logic signed [SAMPLE_BITS-1:0] n_win [KS][KS];
    logic signed [PROD_BITS-1:0]   r_prod [KS][KS];
    logic signed [RSUM_BITS-1:0]   r_rsum [KS];
    logic signed [SUM_BITS-1:0]    r_filtered;
    logic signed [SUM_BITS-1:0]    n_filtered;

    // shift left, newest column on the right
    always_comb begin
        for (int kr = 0; kr < KS; kr++) begin
            for (int kc = 0; kc < KS - 1; kc++) begin
                n_win[kr][kc] = r_win[kr][kc+1];
            end
        end
        n_win[0][KS-1] = i_top;
        n_win[1][KS-1] = i_mid;
        n_win[2][KS-1] = i_sample;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int kr = 0; kr < KS; kr++) begin
                for (int kc = 0; kc < KS; kc++) begin
                    r_win[kr][kc] <= '0;
                end
            end
        end else if (i_ctl.move1) begin
            r_win <= n_win;
        end
    end

    always_comb begin
        n_filtered = '0;
        for (int kr = 0; kr < KS; kr++) begin
            n_filtered = n_filtered + SUM_BITS'(r_rsum[kr]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.move1) begin
            for (int kr = 0; kr < KS; kr++) begin
                for (int kc = 0; kc < KS; kc++) begin
                    r_prod[kr][kc] <= PROD_BITS'(n_win[kr][kc])
                                    * PROD_BITS'(signed'(i_kernel[kr][kc*CB +: CB]));
                end
            end
        end
        if (i_ctl.move2) begin
            for (int kr = 0; kr < KS; kr++) begin
                r_rsum[kr] <= RSUM_BITS'(r_prod[kr][0]) + RSUM_BITS'(r_prod[kr][1])
                            + RSUM_BITS'(r_prod[kr][2]);
            end
        end
        if (i_ctl.load_out) begin
            r_filtered <= n_filtered;
        end
    end

    assign o_filtered = r_filtered;

endmodule

// ===== hw/rtl/conv2d_valid_window.sv =====
// ----------------------------------------------------------------------------
// conv2d_valid_window: 3x3 correlation over raster samples, inside-frame windows
// Pipeline: products, row sums and the output register follow the accepted sample;
// the line store read is registered together with the accepted sample.
// Throughput: one item per cycle unless stalled; line stores read and write once per cycle.
// Reset: sync active low; clears counters, window, stage valids, sizes to 1024x4096,
// kernel to zero; line stores are not cleared and need two rows before first use.
// ----------------------------------------------------------------------------
module conv2d_valid_window #(
    parameter int MAX_WIDTH   = c2dvw_pkg::MAX_WIDTH,
    parameter int SAMPLE_BITS = c2dvw_pkg::SAMPLE_BITS,
    parameter int SUM_BITS    = SAMPLE_BITS + c2dvw_pkg::COEF_BITS + 3
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [c2dvw_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [c2dvw_pkg::CFG_DATA_BITS-1:0]    i_cfg_data,
    input  logic                                   i_sample_valid,
    output logic                                   o_sample_ready,
    input  logic signed [SAMPLE_BITS-1:0]          i_sample,
    output logic                                   o_result_valid,
    input  logic                                   i_result_ready,
    output logic signed [SUM_BITS-1:0]             o_filtered,
    output logic                                   o_frame_end
);

    localparam int KS       = c2dvw_pkg::KERNEL_SIZE;
    localparam int COL_BITS = $clog2(MAX_WIDTH);
    localparam int CB       = c2dvw_pkg::CMP_BITS;
    localparam int RB       = c2dvw_pkg::ROW_BITS;

    // configuration
    logic [c2dvw_pkg::IMG_W_BITS-1:0]              r_img_w;
    logic [c2dvw_pkg::IMG_H_BITS-1:0]              r_img_h;
    logic [KS-1:0][c2dvw_pkg::KROW_BITS-1:0]       r_kernel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w  <= c2dvw_pkg::IMG_W_BITS'(c2dvw_pkg::IMG_W_RESET);
            r_img_h  <= c2dvw_pkg::IMG_H_BITS'(c2dvw_pkg::IMG_H_RESET);
            r_kernel <= '0;
        end else if (i_cfg_we) begin
            unique case (c2dvw_pkg::t_cfg_idx'(i_cfg_index))
                c2dvw_pkg::CFG_IMAGE_WIDTH: begin
                    r_img_w <= i_cfg_data[c2dvw_pkg::IMG_W_BITS-1:0];
                end
                c2dvw_pkg::CFG_IMAGE_HEIGHT: begin
                    r_img_h <= i_cfg_data[c2dvw_pkg::IMG_H_BITS-1:0];
                end
                c2dvw_pkg::CFG_KERNEL_TOP: begin
                    r_kernel[0] <= i_cfg_data[c2dvw_pkg::KROW_BITS-1:0];
                end
                c2dvw_pkg::CFG_KERNEL_MIDDLE: begin
                    r_kernel[1] <= i_cfg_data[c2dvw_pkg::KROW_BITS-1:0];
                end
                c2dvw_pkg::CFG_KERNEL_BOTTOM: begin
                    r_kernel[2] <= i_cfg_data[c2dvw_pkg::KROW_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // effective frame size, saturated to the supported range
    logic [CB-1:0] eff_w;
    logic [CB-1:0] eff_h;

    always_comb begin
        priority if (CB'(r_img_w) < CB'(c2dvw_pkg::MIN_SIZE)) begin
            eff_w = CB'(c2dvw_pkg::MIN_SIZE);
        end else if (CB'(r_img_w) > CB'(MAX_WIDTH)) begin
            eff_w = CB'(MAX_WIDTH);
        end else begin
            eff_w = CB'(r_img_w);
        end
        priority if (CB'(r_img_h) < CB'(c2dvw_pkg::MIN_SIZE)) begin
            eff_h = CB'(c2dvw_pkg::MIN_SIZE);
        end else if (CB'(r_img_h) > CB'(c2dvw_pkg::MAX_HEIGHT)) begin
            eff_h = CB'(c2dvw_pkg::MAX_HEIGHT);
        end else begin
            eff_h = CB'(r_img_h);
        end
    end

    // pipeline control
    logic r_s1_valid, r_s1_emit, r_s1_last;
    logic r_s2_valid, r_s2_emit, r_s2_last;
    logic r_s3_valid, r_s3_emit, r_s3_last;
    logic r_out_valid, r_out_last;
    logic [COL_BITS-1:0]           r_s1_col;
    logic signed [SAMPLE_BITS-1:0] r_s1_sample;

    logic acc, out_free, mv1, mv2, mv3;
    c2dvw_pkg::t_pipe_ctl pipe_ctl;

    assign out_free = !r_out_valid || i_result_ready;
    assign mv3      = r_s3_valid && (!r_s3_emit || out_free);
    assign mv2      = r_s2_valid && (!r_s3_valid || mv3);
    assign mv1      = r_s1_valid && (!r_s2_valid || mv2);
    assign o_sample_ready = !r_s1_valid || mv1;
    assign acc      = i_sample_valid && o_sample_ready;

    assign pipe_ctl.move1    = mv1;
    assign pipe_ctl.move2    = mv2;
    assign pipe_ctl.load_out = mv3 && r_s3_emit;

    // raster position of the next item
    logic [COL_BITS-1:0] r_col;
    logic [RB-1:0]       r_row;
    logic [CB-1:0]       col_ext, row_ext;
    logic                col_wrap, row_wrap, emit, last;

    assign col_ext  = CB'(r_col);
    assign row_ext  = CB'(r_row);
    assign col_wrap = (col_ext + CB'(1)) >= eff_w;
    assign row_wrap = (row_ext + CB'(1)) >= eff_h;
    assign emit     = (row_ext >= CB'(KS - 1)) && (col_ext >= CB'(KS - 1));
    assign last     = (row_ext == eff_h - CB'(1)) && (col_ext == eff_w - CB'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (acc) begin
            if (col_wrap) begin
                r_col <= '0;
                r_row <= row_wrap ? '0 : RB'(row_ext + CB'(1));
            end else begin
                r_col <= COL_BITS'(col_ext + CB'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (acc) begin
                r_s1_valid <= 1'b1;
            end else if (mv1) begin
                r_s1_valid <= 1'b0;
            end
            if (mv1) begin
                r_s2_valid <= 1'b1;
            end else if (mv2) begin
                r_s2_valid <= 1'b0;
            end
            if (mv2) begin
                r_s3_valid <= 1'b1;
            end else if (mv3) begin
                r_s3_valid <= 1'b0;
            end
            if (pipe_ctl.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_result_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_col    <= r_col;
            r_s1_sample <= i_sample;
            r_s1_emit   <= emit;
            r_s1_last   <= last;
        end
        if (mv1) begin
            r_s2_emit <= r_s1_emit;
            r_s2_last <= r_s1_last;
        end
        if (mv2) begin
            r_s3_emit <= r_s2_emit;
            r_s3_last <= r_s2_last;
        end
        if (pipe_ctl.load_out) begin
            r_out_last <= r_s3_last;
        end
    end

    logic signed [SAMPLE_BITS-1:0] lb_top, lb_mid;

    c2dvw_linebuf #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_WIDTH   (MAX_WIDTH),
        .ADDR_BITS   (COL_BITS)
    ) u_linebuf (
        .i_clk       (i_clk),
        .i_rd_en     (acc),
        .i_rd_addr   (r_col),
        .i_wr_en     (mv1),
        .i_wr_addr   (r_s1_col),
        .i_wr_sample (r_s1_sample),
        .o_top       (lb_top),
        .o_mid       (lb_mid)
    );

    c2dvw_mac #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_BITS    (SUM_BITS)
    ) u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (pipe_ctl),
        .i_top      (lb_top),
        .i_mid      (lb_mid),
        .i_sample   (r_s1_sample),
        .i_kernel   (r_kernel),
        .o_filtered (o_filtered)
    );

    assign o_result_valid = r_out_valid;
    assign o_frame_end    = r_out_last;

    // a line store entry is never read and written in the same cycle
    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && mv1) |-> (r_col != r_s1_col))
        else $error("line store read/write address collision");

    // the frame's last position is always a full window
    a_last_is_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_last) |-> r_s1_emit)
        else $error("frame end flagged on a position without a result");

    // an output load never overwrites a result that was not taken
    a_out_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pipe_ctl.load_out |-> (!r_out_valid || i_result_ready))
        else $error("output register overwritten");

    // results leave only after an item has crossed the row-sum stage
    a_out_from_s3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(o_result_valid)) |-> $past(r_s3_valid && r_s3_emit))
        else $error("result appeared without a stage-3 item");

endmodule
